/* rtl/mptl_pkg.sv */
// Shared constants, codes and structures of the MIDI patch table lookup.
package mptl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W     = 30;
    localparam int PATCH_W     = 24;
    localparam int BANK_W      = 9;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // Operation codes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_FIND  = 2'd1;
    localparam logic [1:0] OP_NEXT  = 2'd2;
    localparam logic [1:0] OP_PREV  = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_WRITTEN = 2'd0;
    localparam logic [1:0] STAT_FOUND   = 2'd1;
    localparam logic [1:0] STAT_NONE    = 2'd2;
    localparam logic [1:0] STAT_GM_DRUM = 2'd3;

    // Song modes.
    localparam logic [1:0] MODE_GM    = 2'd0;
    localparam logic [1:0] MODE_GS    = 2'd1;
    localparam logic [1:0] MODE_XG    = 2'd2;
    localparam logic [1:0] MODE_OTHER = 2'd3;

    // Configuration register indexes.
    localparam logic REG_ENTRIES = 1'b0;
    localparam logic REG_DRUM    = 1'b1;

    localparam logic [7:0]         BYTE_ANY   = 8'hFF;
    localparam logic [BANK_W-1:0]  BANK_ANY   = 9'h1FF;
    localparam logic [PATCH_W-1:0] GM_DRUM_KIT = 24'hFFFF00;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [IDX_W-1:0]  entry_index;
        logic [2:0]        entry_types;
        logic [7:0]        entry_prog;
        logic [BANK_W-1:0] entry_high_bank;
        logic [BANK_W-1:0] entry_low_bank;
        logic              entry_is_drum;
        logic [3:0]        channel;
        logic [PATCH_W-1:0] query_patch;
        logic              query_unknown;
        logic [1:0]        song_mode;
        logic              want_drum;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   match_index;
        logic [PATCH_W-1:0] patch_word;
    } result_t;

    // Query as the compare unit sees it for the whole scan.
    typedef struct packed {
        logic       is_find;
        logic [2:0] tmask;
        logic       hb_use;
        logic       lb_use;
        logic       any_drum;
        logic       drumchan;
        logic [7:0] prog;
        logic [7:0] qh;
        logic [7:0] ql;
    } query_t;

    typedef struct packed {
        logic               listed;
        logic               find_hit;
        logic               list_eq;
        logic [PATCH_W-1:0] word;
    } match_t;

endpackage

/* rtl/mptl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mptl_ram #(
    parameter int DATA_W = 30,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mptl_match.sv */
// Entry compare unit: mode filter, find match, list equality and result packing.
module mptl_match import mptl_pkg::*; (
    input  logic [ENTRY_W-1:0] entry,
    input  query_t             query,
    output match_t             result
);

    logic [2:0]        types;
    logic [7:0]        prog;
    logic [BANK_W-1:0] hbank;
    logic [BANK_W-1:0] lbank;
    logic              drum;
    logic              filt;
    logic              hb_ok;
    logic              lb_ok;
    logic [BANK_W-1:0] eh9;
    logic [BANK_W-1:0] el9;
    logic [BANK_W-1:0] qh9;
    logic [BANK_W-1:0] ql9;

    always_comb begin
        types = entry[2:0];
        prog  = entry[10:3];
        hbank = entry[19:11];
        lbank = entry[28:20];
        drum  = entry[29];

        filt = (|(types & query.tmask)) && (query.any_drum || (drum == query.drumchan));

        hb_ok = !query.hb_use || (hbank == BANK_ANY) || (hbank == {1'b0, query.qh});
        lb_ok = !query.lb_use || (lbank == BANK_ANY) || (lbank == {1'b0, query.ql});

        // In list form a bank that the mode ignores counts as any bank.
        eh9 = (!query.hb_use || (hbank == BANK_ANY)) ? BANK_ANY : hbank;
        el9 = (!query.lb_use || (lbank == BANK_ANY)) ? BANK_ANY : lbank;
        qh9 = (query.qh == BYTE_ANY) ? BANK_ANY : {1'b0, query.qh};
        ql9 = (query.ql == BYTE_ANY) ? BANK_ANY : {1'b0, query.ql};

        result.listed   = filt;
        result.find_hit = filt && (prog == query.prog) && hb_ok && lb_ok;
        result.list_eq  = filt && (prog == query.prog) && (eh9 == qh9) && (el9 == ql9);
        if (query.is_find) begin
            result.word = {hbank[7:0], lbank[7:0], prog};
        end else begin
            result.word = {eh9[7:0], el9[7:0], prog};
        end
    end

endmodule

/* rtl/mptl_ctrl.sv */
// Scan sequencer: table RAM, shared compare unit, running search state, result register.
module mptl_ctrl import mptl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    input  logic [CNT_W-1:0] entries_in_use,
    input  logic [3:0]       drum_channel,
    output logic             out_valid,
    input  logic             out_ready,
    output result_t          out_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t             state_reg;
    query_t             query_reg;
    logic [1:0]         op_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   addr_reg;
    logic               pend_valid_reg;
    logic [IDX_W-1:0]   pend_idx_reg;
    result_t            res_reg;
    result_t            out_reg;
    logic               out_valid_reg;

    logic               any_reg;
    logic               found_reg;
    logic               run_reg;
    logic               prev_set_reg;
    logic               next_set_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   first_idx_reg;
    logic [PATCH_W-1:0] first_word_reg;
    logic [IDX_W-1:0]   last_idx_reg;
    logic [PATCH_W-1:0] last_word_reg;
    logic [IDX_W-1:0]   prev_idx_reg;
    logic [PATCH_W-1:0] prev_word_reg;
    logic [IDX_W-1:0]   next_idx_reg;
    logic [PATCH_W-1:0] next_word_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [PATCH_W-1:0] hit_word_reg;

    logic               accept;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    match_t             cmp;
    query_t             query_in;
    logic               drumchan_in;
    logic [CNT_W-1:0]   n_in;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign ram_we    = accept && (in_item.opcode == OP_WRITE);
    assign ram_wdata = {in_item.entry_is_drum, in_item.entry_low_bank,
                        in_item.entry_high_bank, in_item.entry_prog, in_item.entry_types};
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    mptl_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_item.entry_index),
        .wdata (ram_wdata),
        .raddr (addr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    mptl_match u_match (
        .entry  (ram_rdata),
        .query  (query_reg),
        .result (cmp)
    );

    always_comb begin
        drumchan_in = (in_item.channel == drum_channel);
        n_in = (entries_in_use > DEPTH_CNT) ? DEPTH_CNT : entries_in_use;

        query_in.is_find  = (in_item.opcode == OP_FIND);
        query_in.any_drum = in_item.want_drum && (in_item.song_mode != MODE_GM);
        query_in.drumchan = drumchan_in;
        query_in.prog     = in_item.query_patch[7:0];
        query_in.ql       = in_item.query_patch[15:8];
        query_in.qh       = in_item.query_patch[23:16];
        case (in_item.song_mode)
            MODE_GM: begin
                query_in.tmask  = 3'b001;
                query_in.hb_use = 1'b0;
                query_in.lb_use = 1'b0;
            end
            MODE_GS: begin
                query_in.tmask  = 3'b010;
                query_in.hb_use = 1'b1;
                query_in.lb_use = 1'b0;
            end
            MODE_XG: begin
                query_in.tmask  = 3'b100;
                query_in.hb_use = 1'b1;
                query_in.lb_use = 1'b1;
            end
            default: begin
                query_in.tmask  = 3'b001;
                query_in.hb_use = 1'b1;
                query_in.lb_use = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            // In S_DONE the output register is reloaded below instead.
            if (out_valid_reg && out_ready && (state_reg != S_DONE)) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        query_reg      <= query_in;
                        op_reg         <= in_item.opcode;
                        n_reg          <= n_in;
                        addr_reg       <= '0;
                        pend_valid_reg <= 1'b0;
                        any_reg        <= 1'b0;
                        found_reg      <= 1'b0;
                        run_reg        <= 1'b0;
                        prev_set_reg   <= 1'b0;
                        next_set_reg   <= 1'b0;
                        hit_reg        <= 1'b0;
                        if (in_item.opcode == OP_WRITE) begin
                            res_reg   <= '{STAT_WRITTEN, in_item.entry_index, '0};
                            state_reg <= S_DONE;
                        end else if (query_in.is_find && (in_item.query_unknown ||
                                     (query_in.prog == BYTE_ANY))) begin
                            res_reg   <= '{STAT_NONE, '0, '0};
                            state_reg <= S_DONE;
                        end else if (query_in.is_find && (in_item.song_mode == MODE_GM) &&
                                     drumchan_in) begin
                            res_reg   <= '{STAT_GM_DRUM, '0, GM_DRUM_KIT};
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    // One read is issued per cycle; its data is judged in the next cycle.
                    if (addr_reg < n_reg) begin
                        pend_valid_reg <= 1'b1;
                        pend_idx_reg   <= addr_reg[IDX_W-1:0];
                        addr_reg       <= addr_reg + 1'b1;
                    end else begin
                        pend_valid_reg <= 1'b0;
                    end

                    if (pend_valid_reg) begin
                        if (query_reg.is_find) begin
                            if (cmp.find_hit && !hit_reg) begin
                                hit_reg      <= 1'b1;
                                hit_idx_reg  <= pend_idx_reg;
                                hit_word_reg <= cmp.word;
                            end
                        end else if (cmp.listed) begin
                            if (!any_reg) begin
                                first_idx_reg  <= pend_idx_reg;
                                first_word_reg <= cmp.word;
                            end
                            any_reg       <= 1'b1;
                            last_idx_reg  <= pend_idx_reg;
                            last_word_reg <= cmp.word;
                            if (!found_reg) begin
                                if (cmp.list_eq) begin
                                    found_reg <= 1'b1;
                                    run_reg   <= 1'b1;
                                    // The entry listed just before the first equal one.
                                    if (any_reg) begin
                                        prev_set_reg  <= 1'b1;
                                        prev_idx_reg  <= last_idx_reg;
                                        prev_word_reg <= last_word_reg;
                                    end
                                end
                            end else if (run_reg && !cmp.list_eq) begin
                                run_reg       <= 1'b0;
                                next_set_reg  <= 1'b1;
                                next_idx_reg  <= pend_idx_reg;
                                next_word_reg <= cmp.word;
                            end
                        end
                    end

                    if (!(addr_reg < n_reg) && !pend_valid_reg) begin
                        state_reg <= S_DONE;
                        if (query_reg.is_find) begin
                            if (hit_reg) begin
                                res_reg <= '{STAT_FOUND, hit_idx_reg, hit_word_reg};
                            end else begin
                                res_reg <= '{STAT_NONE, '0, '0};
                            end
                        end else if (!any_reg) begin
                            res_reg <= '{STAT_NONE, '0, '0};
                        end else if (!found_reg) begin
                            res_reg <= '{STAT_FOUND, first_idx_reg, first_word_reg};
                        end else if (op_reg == OP_NEXT) begin
                            if (next_set_reg) begin
                                res_reg <= '{STAT_FOUND, next_idx_reg, next_word_reg};
                            end else begin
                                res_reg <= '{STAT_FOUND, first_idx_reg, first_word_reg};
                            end
                        end else begin
                            if (prev_set_reg) begin
                                res_reg <= '{STAT_FOUND, prev_idx_reg, prev_word_reg};
                            end else begin
                                res_reg <= '{STAT_FOUND, last_idx_reg, last_word_reg};
                            end
                        end
                    end
                end

                S_DONE: begin
                    if (!out_valid_reg || out_ready) begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/midi_patch_table_lookup.sv */
// A write goes straight to the result register; find, next and previous scan the first
// entries_in_use entries (at most 64), reading one RAM entry per cycle through the shared
// compare unit, unless a find is answered without a scan (unknown patch or GM drum).
// A new beat is taken once the last one has left the sequencer, also while its result waits.
// Reset (aresetn, synchronous, active low) clears the sequencer and output valid, sets
// entries_in_use to 0 and drum_channel to 9; table contents are undefined until written.
module midi_patch_table_lookup import mptl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index, entry_types, entry_prog, entry_high_bank, entry_low_bank,
    // entry_is_drum, channel, query_patch, query_unknown, song_mode, want_drum
    input  logic [71:0] s_tdata,
    // opcode
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // match_index, patch_word
    output logic [31:0] m_tdata,
    // status
    output logic [1:0]  m_tuser
);

    logic [CNT_W-1:0] entries_in_use_reg;
    logic [3:0]       drum_channel_reg;
    logic             cfg_write;
    in_item_t         item;
    result_t          res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_in_use_reg <= '0;
            drum_channel_reg   <= 4'd9;
        end else if (cfg_write) begin
            if (paddr[2] == REG_ENTRIES) begin
                entries_in_use_reg <= pwdata[CNT_W-1:0];
            end else begin
                drum_channel_reg <= pwdata[3:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_DRUM) begin
            prdata = {28'd0, drum_channel_reg};
        end else begin
            prdata = {{(32-CNT_W){1'b0}}, entries_in_use_reg};
        end
    end

    always_comb begin
        item.opcode          = s_tuser;
        item.entry_index     = s_tdata[5:0];
        item.entry_types     = s_tdata[8:6];
        item.entry_prog      = s_tdata[16:9];
        item.entry_high_bank = s_tdata[25:17];
        item.entry_low_bank  = s_tdata[34:26];
        item.entry_is_drum   = s_tdata[35];
        item.channel         = s_tdata[39:36];
        item.query_patch     = s_tdata[63:40];
        item.query_unknown   = s_tdata[64];
        item.song_mode       = s_tdata[66:65];
        item.want_drum       = s_tdata[67];
    end

    mptl_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_item        (item),
        .entries_in_use (entries_in_use_reg),
        .drum_channel   (drum_channel_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_item       (res)
    );

    assign m_tdata = {2'b00, res.patch_word, res.match_index};
    assign m_tuser = res.status;

endmodule

/* tb/sv/midi_patch_table_lookup_tb.sv */
// Self-checking stream testbench for the MIDI patch table lookup block.
module midi_patch_table_lookup_tb import mptl_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_W = $bits(in_item_t);
    localparam int LIMIT  = 1000000;

    typedef struct packed {
        logic [2:0] types;
        logic [7:0] prog;
        logic [8:0] hbank;
        logic [8:0] lbank;
        logic       drum;
    } patch_entry_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    in_item_t     pending_items[$];
    result_t      expected_results[$];
    patch_entry_t model_table[TABLE_DEPTH];
    logic [6:0]   in_use_reg = 7'd0;
    logic [3:0]   drum_chan_reg = 4'd9;
    in_item_t     offered;
    result_t      got, exp_r;
    int           send_idle_pct = 33;
    int           recv_idle_pct = 75;
    int           stall_left = 0;
    int           received = 0;
    int           err_count = 0;
    int           cycle_count;

    midi_patch_table_lookup dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    function automatic logic [7:0] bank_code(int b);
        return (b == -1) ? BYTE_ANY : 8'(b);
    endfunction

    // Appends one beat to the driver's queue.
    function automatic void queue_item(in_item_t it);
        pending_items = {pending_items, it};
    endfunction

    // Works out the result of one accepted beat and applies writes to the table copy.
    function automatic result_t patch_lookup(in_item_t it);
        result_t      r;
        patch_entry_t e;
        int           n, cnt, k, hb, lb, qh, ql, qprog;
        int           lst_idx[TABLE_DEPTH];
        int           lst_prog[TABLE_DEPTH];
        int           lst_hb[TABLE_DEPTH];
        int           lst_lb[TABLE_DEPTH];
        logic [2:0]   tmask;
        logic         hb_use, lb_use, drumchan, any_drum;
        r = '0;
        if (it.opcode == OP_WRITE) begin
            model_table[it.entry_index] = '{it.entry_types, it.entry_prog,
                it.entry_high_bank, it.entry_low_bank, it.entry_is_drum};
            r.status = STAT_WRITTEN;
            r.match_index = it.entry_index;
            return r;
        end
        n = (in_use_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(in_use_reg);
        drumchan = (it.channel == drum_chan_reg);
        any_drum = it.want_drum && (it.song_mode != MODE_GM);
        qprog = it.query_patch[7:0];
        ql = it.query_patch[15:8];
        qh = it.query_patch[23:16];
        case (it.song_mode)
            MODE_GM: begin
                tmask = 3'b001; hb_use = 1'b0; lb_use = 1'b0;
            end
            MODE_GS: begin
                tmask = 3'b010; hb_use = 1'b1; lb_use = 1'b0;
            end
            MODE_XG: begin
                tmask = 3'b100; hb_use = 1'b1; lb_use = 1'b1;
            end
            default: begin
                tmask = 3'b001; hb_use = 1'b1; lb_use = 1'b1;
            end
        endcase
        if (it.opcode == OP_FIND) begin
            r.status = STAT_NONE;
            if (it.query_unknown || it.query_patch[7:0] == BYTE_ANY)
                return r;
            if (it.song_mode == MODE_GM && drumchan) begin
                r.status = STAT_GM_DRUM;
                r.patch_word = GM_DRUM_KIT;
                return r;
            end
            for (int i = 0; i < n; i++) begin
                e = model_table[i];
                hb = int'($signed(e.hbank));
                lb = int'($signed(e.lbank));
                if ((e.types & tmask) != 0 && int'(e.prog) == qprog
                        && (any_drum || e.drum == drumchan)
                        && (hb == qh || !hb_use || hb == -1)
                        && (lb == ql || !lb_use || lb == -1)) begin
                    r.status = STAT_FOUND;
                    r.match_index = IDX_W'(i);
                    r.patch_word = {bank_code(hb), bank_code(lb), e.prog};
                    return r;
                end
            end
            return r;
        end
        // Next and previous walk the entries that pass the mode and drum filter.
        cnt = 0;
        for (int i = 0; i < n; i++) begin
            e = model_table[i];
            hb = int'($signed(e.hbank));
            lb = int'($signed(e.lbank));
            if ((e.types & tmask) != 0 && (any_drum || e.drum == drumchan)) begin
                lst_idx[cnt] = i;
                lst_prog[cnt] = e.prog;
                lst_hb[cnt] = (hb == -1 || !hb_use) ? -1 : hb;
                lst_lb[cnt] = (lb == -1 || !lb_use) ? -1 : lb;
                cnt++;
            end
        end
        if (cnt == 0) begin
            r.status = STAT_NONE;
            return r;
        end
        if (ql == 255) ql = -1;
        if (qh == 255) qh = -1;
        k = 0;
        while (k < cnt && !(lst_prog[k] == qprog && lst_lb[k] == ql && lst_hb[k] == qh))
            k++;
        if (k == cnt) begin
            k = 0;
        end else if (it.opcode == OP_NEXT) begin
            while (k < cnt && lst_prog[k] == qprog && lst_lb[k] == ql && lst_hb[k] == qh)
                k++;
            if (k == cnt) k = 0;
        end else begin
            k = (k == 0) ? cnt - 1 : k - 1;
        end
        r.status = STAT_FOUND;
        r.match_index = IDX_W'(lst_idx[k]);
        r.patch_word = {bank_code(lst_hb[k]), bank_code(lst_lb[k]), 8'(lst_prog[k])};
        return r;
    endfunction

    function automatic in_item_t random_bits();
        return in_item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
    endfunction

    // Banks lean toward "any" and a few small values so that lists hold equal runs.
    function automatic logic [8:0] rand_bank();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) return BANK_ANY;
        else if (sel < 80) return 9'($urandom_range(3));
        else if (sel < 90) return 9'($urandom_range(255));
        else return 9'($urandom);
    endfunction

    function automatic in_item_t make_write(int idx, int types, int prog, int hb, int lb,
                                            int drum);
        in_item_t it;
        it = random_bits();
        it.opcode = OP_WRITE;
        it.entry_index = IDX_W'(idx);
        it.entry_types = 3'(types);
        it.entry_prog = 8'(prog);
        it.entry_high_bank = 9'(hb);
        it.entry_low_bank = 9'(lb);
        it.entry_is_drum = 1'(drum);
        return it;
    endfunction

    function automatic in_item_t make_query(logic [1:0] op, logic [1:0] mode, int chan,
                                            logic [23:0] patch, logic unk, logic want);
        in_item_t it;
        it = random_bits();
        it.opcode = op;
        it.song_mode = mode;
        it.channel = 4'(chan);
        it.query_patch = patch;
        it.query_unknown = unk;
        it.want_drum = want;
        return it;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t     it;
        patch_entry_t e;
        int           sel, span;
        it = random_bits();
        sel = $urandom_range(99);
        if (sel < 25) it.opcode = OP_WRITE;
        else if (sel < 60) it.opcode = OP_FIND;
        else if (sel < 80) it.opcode = OP_NEXT;
        else it.opcode = OP_PREV;
        it.entry_prog = ($urandom_range(9) < 8) ? 8'($urandom_range(5)) : 8'($urandom);
        it.entry_high_bank = rand_bank();
        it.entry_low_bank = rand_bank();
        if ($urandom_range(9) < 4) it.channel = drum_chan_reg;
        it.query_unknown = ($urandom_range(9) == 0);
        sel = $urandom_range(99);
        if (sel < 70) begin
            // Most queries name a patch that sits in the searched part of the table.
            span = (in_use_reg == 0) ? 1 : ((in_use_reg > TABLE_DEPTH) ? TABLE_DEPTH
                                                                      : int'(in_use_reg));
            e = model_table[$urandom_range(span - 1)];
            it.query_patch = {bank_code(int'($signed(e.hbank))),
                              bank_code(int'($signed(e.lbank))), e.prog};
            if ($urandom_range(2) == 0) it.query_patch[23:8] = {BYTE_ANY, BYTE_ANY};
        end else if (sel < 85) begin
            it.query_patch = {8'($urandom_range(3)), 8'($urandom_range(3)),
                              8'($urandom_range(5))};
        end
        return it;
    endfunction

    task automatic wait_idle();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ENTRIES) in_use_reg = value[6:0];
        else drum_chan_reg = value[3:0];
    endtask

    // Lets the block drain, sets both registers and queues a batch of random beats.
    task automatic run_phase(int count, int entries, int drum, int spct, int rpct);
        wait_idle();
        write_reg(REG_ENTRIES, 32'(entries));
        write_reg(REG_DRUM, 32'(drum));
        send_idle_pct = spct;
        recv_idle_pct = rpct;
        repeat (count) queue_item(rand_item());
    endtask

    // Input side: a beat moves when tvalid and tready are both high at the edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results = {expected_results, patch_lookup(offered)};
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= offered.opcode;
                    s_tdata <= {4'b0, offered.want_drum, offered.song_mode,
                                offered.query_unknown, offered.query_patch, offered.channel,
                                offered.entry_is_drum, offered.entry_low_bank,
                                offered.entry_high_bank, offered.entry_prog,
                                offered.entry_types, offered.entry_index};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: compares each beat with the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.match_index = m_tdata[IDX_W-1:0];
                got.patch_word = m_tdata[IDX_W +: PATCH_W];
                if (expected_results.size() == 0) begin
                    err_count++;
                    $display("%0t: result with nothing expected: status %0d index %0d patch %h",
                             $time, got.status, got.match_index, got.patch_word);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        err_count++;
                        $display("%0t: expected st %0d idx %0d patch %h, got st %0d idx %0d %h",
                                 $time, exp_r.status, exp_r.match_index, exp_r.patch_word,
                                 got.status, got.match_index, got.patch_word);
                    end
                end
                received++;
                // Long hold-offs so that the block backs up and drops s_tready.
                if (received == 300 || received == 1000) stall_left = 500;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        for (cycle_count = 0; cycle_count < LIMIT; cycle_count++) @(posedge aclk);
        $display("midi_patch_table_lookup_tb: errors");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty table after reset: nothing is searched, but the drum kit still answers.
        queue_item(make_query(OP_FIND, MODE_GS, 0, 24'h00000A, 1'b0, 1'b0));
        queue_item(make_query(OP_NEXT, MODE_XG, 0, 24'h010203, 1'b0, 1'b1));
        queue_item(make_query(OP_PREV, MODE_OTHER, 1, 24'hFFFFFF, 1'b0, 1'b0));
        queue_item(make_query(OP_FIND, MODE_GM, 9, 24'h000000, 1'b0, 1'b0));
        queue_item(make_query(OP_FIND, MODE_GS, 0, 24'h000000, 1'b1, 1'b0));
        queue_item(make_query(OP_FIND, MODE_XG, 0, 24'h0000FF, 1'b0, 1'b0));

        // Fill every slot; the first few hold the corner entries.
        queue_item(make_write(0, 7, 255, -1, -1, 0));
        queue_item(make_write(1, 1, 0, 0, 0, 1));
        queue_item(make_write(2, 2, 10, 255, 255, 0));
        queue_item(make_write(3, 4, 10, -256, 3, 0));
        queue_item(make_write(4, 0, 10, 5, 5, 0));
        queue_item(make_write(5, 7, 10, 255, 255, 0));
        for (int i = 6; i < TABLE_DEPTH; i++) begin
            offered = rand_item();
            queue_item(make_write(i, offered.entry_types, offered.entry_prog,
                int'($signed(offered.entry_high_bank)), int'($signed(offered.entry_low_bank)),
                offered.entry_is_drum));
        end

        run_phase(0, TABLE_DEPTH, 9, 33, 75);
        queue_item(make_query(OP_FIND, MODE_GS, 0, 24'hFFFF0A, 1'b0, 1'b0));
        queue_item(make_query(OP_FIND, MODE_XG, 0, 24'h00030A, 1'b0, 1'b0));
        queue_item(make_query(OP_FIND, MODE_OTHER, 0, 24'h000000, 1'b0, 1'b0));
        queue_item(make_query(OP_FIND, MODE_GM, 0, 24'h000000, 1'b0, 1'b0));
        queue_item(make_query(OP_FIND, MODE_GM, 9, 24'h000000, 1'b0, 1'b0));
        queue_item(make_query(OP_FIND, MODE_GS, 9, 24'h050500, 1'b0, 1'b1));
        queue_item(make_query(OP_NEXT, MODE_GS, 0, 24'hFFFF0A, 1'b0, 1'b0));
        queue_item(make_query(OP_PREV, MODE_GS, 0, 24'hFFFF0A, 1'b0, 1'b0));
        queue_item(make_query(OP_NEXT, MODE_XG, 0, 24'h123456, 1'b0, 1'b0));
        queue_item(make_query(OP_PREV, MODE_OTHER, 0, 24'hFFFFFF, 1'b0, 1'b0));
        queue_item(make_query(OP_NEXT, MODE_GM, 9, 24'hFFFF00, 1'b1, 1'b0));
        queue_item(make_query(OP_PREV, MODE_GM, 9, 24'hFFFF00, 1'b0, 1'b1));
        queue_item(make_query(OP_NEXT, MODE_XG, 0, 24'h00030A, 1'b0, 1'b0));
        queue_item(make_query(OP_PREV, MODE_XG, 0, 24'h00030A, 1'b0, 1'b0));

        run_phase(250, TABLE_DEPTH, 9, 33, 75);
        run_phase(100, 1, 0, 33, 75);
        // A count above the table depth saturates.
        run_phase(250, 100, 15, 33, 75);
        run_phase(250, $urandom_range(2, 63), $urandom_range(15), 75, 33);
        run_phase(50, 0, 9, 75, 33);
        run_phase(200, TABLE_DEPTH, $urandom_range(15), 0, 0);
        run_phase(250, $urandom_range(1, TABLE_DEPTH), 9, 0, 0);

        wait_idle();
        repeat (80) @(posedge aclk);
        if (err_count == 0)
            $display("midi_patch_table_lookup_tb: clean");
        else
            $display("midi_patch_table_lookup_tb: errors");
        $finish;
    end

endmodule
